@@ sv/pga_pkg.sv @@
package pga_pkg;

    localparam int NUM_PAGES_DEF  = 32;
    localparam int PAGE_UNITS_DEF = 4;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_KILL = 2'd1,
        MODE_FRAG = 2'd2,
        MODE_MEM  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_ALLOC,
        OP_KILL,
        OP_FRAG,
        OP_SET_ERR,
        OP_RESP
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_MODE_ADD,
        C_MODE_KILL,
        C_MODE_FRAG,
        C_NO_FIT,
        C_REM_NZ,
        C_NOT_LAST,
        C_OUT_FREE
    } cond_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram step addresses.
    localparam upc_t S_FETCH     = 4'd0;
    localparam upc_t S_DISP_ADD  = 4'd1;
    localparam upc_t S_DISP_KILL = 4'd2;
    localparam upc_t S_DISP_FRAG = 4'd3;
    localparam upc_t S_MEM       = 4'd4;
    localparam upc_t S_ADD_CHK   = 4'd5;
    localparam upc_t S_ADD_LOOP  = 4'd6;
    localparam upc_t S_ADD_END   = 4'd7;
    localparam upc_t S_KILL_LOOP = 4'd8;
    localparam upc_t S_KILL_END  = 4'd9;
    localparam upc_t S_FRAG_LOOP = 4'd10;
    localparam upc_t S_FRAG_END  = 4'd11;
    localparam upc_t S_ERR       = 4'd12;
    localparam upc_t S_RESP      = 4'd13;

    // When cond is true the step jumps to target; otherwise it advances
    // to the next address, or stays put if hold is set.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
        logic  hold;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } ctrl_t;

    typedef struct packed {
        logic mode_add;
        logic mode_kill;
        logic mode_frag;
        logic no_fit;
        logic rem_nz;
        logic not_last;
    } dp_flags_t;

    typedef struct packed {
        logic       status;
        logic [4:0] fragment_count;
        logic [7:0] free_memory;
        logic [5:0] pages_changed;
    } result_t;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        case (addr)
            S_FETCH:     w = '{OP_LATCH,   C_ACCEPT,    S_DISP_ADD,  1'b1};
            S_DISP_ADD:  w = '{OP_NONE,    C_MODE_ADD,  S_ADD_CHK,   1'b0};
            S_DISP_KILL: w = '{OP_NONE,    C_MODE_KILL, S_KILL_LOOP, 1'b0};
            S_DISP_FRAG: w = '{OP_NONE,    C_MODE_FRAG, S_FRAG_LOOP, 1'b0};
            S_MEM:       w = '{OP_NONE,    C_ALWAYS,    S_RESP,      1'b0};
            S_ADD_CHK:   w = '{OP_NONE,    C_NO_FIT,    S_ERR,       1'b0};
            S_ADD_LOOP:  w = '{OP_ALLOC,   C_REM_NZ,    S_ADD_LOOP,  1'b0};
            S_ADD_END:   w = '{OP_NONE,    C_ALWAYS,    S_RESP,      1'b0};
            S_KILL_LOOP: w = '{OP_KILL,    C_NOT_LAST,  S_KILL_LOOP, 1'b0};
            S_KILL_END:  w = '{OP_NONE,    C_ALWAYS,    S_RESP,      1'b0};
            S_FRAG_LOOP: w = '{OP_FRAG,    C_NOT_LAST,  S_FRAG_LOOP, 1'b0};
            S_FRAG_END:  w = '{OP_NONE,    C_ALWAYS,    S_RESP,      1'b0};
            S_ERR:       w = '{OP_SET_ERR, C_ALWAYS,    S_RESP,      1'b0};
            S_RESP:      w = '{OP_RESP,    C_OUT_FREE,  S_FETCH,     1'b1};
            default:     w = '{OP_NONE,    C_ALWAYS,    S_FETCH,     1'b0};
        endcase
        return w;
    endfunction

endpackage

@@ sv/pga_seq.sv @@
module pga_seq import pga_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      out_free,
    input  dp_flags_t flags,
    output logic      s_ready,
    output ctrl_t     ctrl
);

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t uword;
    logic   cond_true;

    always_comb begin
        uword   = ucode_rom(upc_reg);
        s_ready = (upc_reg == S_FETCH);
        case (uword.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_ACCEPT:    cond_true = s_valid;
            C_MODE_ADD:  cond_true = flags.mode_add;
            C_MODE_KILL: cond_true = flags.mode_kill;
            C_MODE_FRAG: cond_true = flags.mode_frag;
            C_NO_FIT:    cond_true = flags.no_fit;
            C_REM_NZ:    cond_true = flags.rem_nz;
            C_NOT_LAST:  cond_true = flags.not_last;
            C_OUT_FREE:  cond_true = out_free;
            default:     cond_true = 1'b0;
        endcase
        if (cond_true) begin
            upc_next = uword.target;
        end else if (uword.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
        ctrl.op     = uword.op;
        ctrl.accept = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    a_accept_leaves_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.accept |=> !s_ready)
        else $error("sequencer stayed in fetch after accepting a request");

endmodule

@@ sv/pga_dp.sv @@
module pga_dp import pga_pkg::*; #(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_UNITS = PAGE_UNITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_t      ctrl,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_program_id,
    input  logic [7:0] s_program_size,
    output dp_flags_t  flags,
    output result_t    result
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int PROD_W = CNT_W + $clog2(PAGE_UNITS + 1);
    localparam int CMP_W  = (PROD_W > 8) ? PROD_W : 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);
    localparam logic [7:0]       UNITS8   = 8'(PAGE_UNITS);

    // Owner table and free queue storage.
    logic [7:0]       owner_mem [NUM_PAGES];
    logic [IDX_W-1:0] queue_mem [NUM_PAGES];

    mode_t            mode_reg;
    logic [7:0]       id_reg;
    logic [7:0]       rem_reg, rem_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] frag_reg, frag_next;
    logic [CNT_W-1:0] changed_reg, changed_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic             status_reg, status_next;
    logic             prev_reg, prev_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [NUM_PAGES-1:0] used_reg, used_next;
    logic [NUM_PAGES-1:0] qvalid_reg, qvalid_next;

    logic [7:0]       owner_rd_reg;
    logic [IDX_W-1:0] qmem_rd_reg;
    logic [IDX_W-1:0] qaddr_rd_reg;
    logic             qvalid_rd_reg;

    logic [IDX_W-1:0] alloc_page;
    logic             alloc_en;
    logic             kill_hit;
    logic [CMP_W-1:0] free_units;
    logic [31:0]      frag_wide;
    logic [31:0]      changed_wide;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // A queue slot that was never written stands for the page whose number is its own address.
    assign alloc_page = qvalid_rd_reg ? qmem_rd_reg : qaddr_rd_reg;
    assign alloc_en   = (ctrl.op == OP_ALLOC) && (rem_reg != '0);
    assign kill_hit   = (ctrl.op == OP_KILL) && used_reg[idx_reg] && (owner_rd_reg == id_reg);
    assign free_units = CMP_W'(free_reg) * CMP_W'(PAGE_UNITS);

    always_comb begin
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        frag_next    = frag_reg;
        changed_next = changed_reg;
        free_next    = free_reg;
        status_next  = status_reg;
        prev_next    = prev_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        used_next    = used_reg;
        qvalid_next  = qvalid_reg;
        case (ctrl.op)
            OP_LATCH: begin
                if (ctrl.accept) begin
                    rem_next     = s_program_size;
                    idx_next     = '0;
                    frag_next    = '0;
                    changed_next = '0;
                    status_next  = 1'b0;
                    prev_next    = 1'b0;
                end
            end
            OP_ALLOC: begin
                if (alloc_en) begin
                    used_next[alloc_page] = 1'b1;
                    head_next    = wrap_inc(head_reg);
                    free_next    = free_reg - 1'b1;
                    changed_next = changed_reg + 1'b1;
                    rem_next     = (rem_reg > UNITS8) ? rem_reg - UNITS8 : '0;
                end
            end
            OP_KILL: begin
                if (kill_hit) begin
                    used_next[idx_reg]   = 1'b0;
                    qvalid_next[tail_reg] = 1'b1;
                    tail_next    = wrap_inc(tail_reg);
                    free_next    = free_reg + 1'b1;
                    changed_next = changed_reg + 1'b1;
                end
                idx_next = wrap_inc(idx_reg);
            end
            OP_FRAG: begin
                // A fragment is a used page whose upper neighbor is free.
                if ((idx_reg != '0) && prev_reg && !used_reg[idx_reg]) begin
                    frag_next = frag_reg + 1'b1;
                end
                prev_next = used_reg[idx_reg];
                idx_next  = wrap_inc(idx_reg);
            end
            OP_SET_ERR: begin
                status_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= CNT_W'(NUM_PAGES);
            used_reg   <= '0;
            qvalid_reg <= '0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            qvalid_reg <= qvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            mode_reg <= mode_t'(s_mode);
            id_reg   <= s_program_id;
        end
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        frag_reg    <= frag_next;
        changed_reg <= changed_next;
        status_reg  <= status_next;
        prev_reg    <= prev_next;
    end

    // Reads are issued at the next index and head so the data lines up with
    // the registers on the following cycle.
    always_ff @(posedge aclk) begin
        owner_rd_reg  <= owner_mem[idx_next];
        qmem_rd_reg   <= queue_mem[head_next];
        qaddr_rd_reg  <= head_next;
        qvalid_rd_reg <= qvalid_next[head_next];
        if (alloc_en) begin
            owner_mem[alloc_page] <= id_reg;
        end
        if (kill_hit) begin
            queue_mem[tail_reg] <= idx_reg;
        end
    end

    assign frag_wide    = 32'(frag_reg);
    assign changed_wide = 32'(changed_reg);

    always_comb begin
        flags.mode_add  = (mode_reg == MODE_ADD);
        flags.mode_kill = (mode_reg == MODE_KILL);
        flags.mode_frag = (mode_reg == MODE_FRAG);
        flags.no_fit    = CMP_W'(rem_reg) > free_units;
        flags.rem_nz    = (rem_reg != '0);
        flags.not_last  = (idx_reg != LAST_IDX);

        result.status         = status_reg;
        result.fragment_count = (mode_reg == MODE_FRAG) ? frag_wide[4:0] : '0;
        result.free_memory    = (mode_reg == MODE_MEM) ? free_units[7:0] : '0;
        result.pages_changed  = changed_wide[5:0];
    end

    a_page_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(used_reg) + int'(free_reg)) == NUM_PAGES)
        else $error("used pages and free count disagree");

    a_queue_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (((int'(head_reg) + int'(free_reg)) >= NUM_PAGES)
            ? (int'(head_reg) + int'(free_reg) - NUM_PAGES)
            : (int'(head_reg) + int'(free_reg))) == int'(tail_reg))
        else $error("free queue span does not match the free page count");

    a_alloc_free_page: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_en |-> !used_reg[alloc_page])
        else $error("allocation popped a page that is already in use");

endmodule

@@ sv/page_allocator_with_owner_table.sv @@
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_mode, s_program_id, s_program_size
// m_      | out       | m_valid / m_ready  | m_status, m_fragment_count,
//         |           |                    | m_free_memory, m_pages_changed
//
// A request passes through a microcoded sequencer that steps one page per cycle.
// Add runs fetch, the mode dispatch, a fit check, then the allocation loop (or the
// error step when refused) and the response; kill and fragment walk every page.
// Synchronous active-low reset; no clearing pass is needed after it.
// A stalled result stays in the output register while the next request is taken;
// the sequencer waits at its response step only when that register is still full.
module page_allocator_with_owner_table import pga_pkg::*; #(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_UNITS = PAGE_UNITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_program_id,
    input  logic [7:0] s_program_size,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [4:0] m_fragment_count,
    output logic [7:0] m_free_memory,
    output logic [5:0] m_pages_changed
);

    ctrl_t     ctrl;
    dp_flags_t flags;
    result_t   result;
    logic      out_free;
    logic      load;
    logic      m_valid_reg, m_valid_next;
    result_t   m_result_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = (ctrl.op == OP_RESP) && out_free;

    pga_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .flags    (flags),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    pga_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_UNITS (PAGE_UNITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .s_mode         (s_mode),
        .s_program_id   (s_program_id),
        .s_program_size (s_program_size),
        .flags          (flags),
        .result         (result)
    );

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_result_reg.status;
    assign m_fragment_count = m_result_reg.fragment_count;
    assign m_free_memory    = m_result_reg.free_memory;
    assign m_pages_changed  = m_result_reg.pages_changed;

endmodule
